FILE: hw/rtl/dcom_pkg.sv
// Shared types and constants for the calibrated offset-to-DAC-code mapper.
// Holds calibration register indexes, reset codes and pipeline stage structs.
// No dependencies.
package dcom_pkg;

  localparam int NUM_CAL   = 7;
  localparam int CODE_W    = 12;
  localparam int MV_W      = 16;
  localparam int CAL_IDX_W = 3;
  localparam int MAG_W     = 19;  // |diff| * offset + bias, worst case 507904
  localparam int QUO_W     = 13;  // quotient, worst case 4914

  typedef logic [CODE_W-1:0]               code_t;
  typedef logic signed [MV_W-1:0]          mv_t;
  typedef logic [NUM_CAL-1:0][CODE_W-1:0]  cal_bank_t;
  typedef logic [CAL_IDX_W-1:0]            cal_idx_t;

  // Calibration register indexes, highest voltage first.
  localparam cal_idx_t CAL_POS375 = 3'd0;
  localparam cal_idx_t CAL_POS250 = 3'd1;
  localparam cal_idx_t CAL_POS125 = 3'd2;
  localparam cal_idx_t CAL_ZERO   = 3'd3;
  localparam cal_idx_t CAL_NEG125 = 3'd4;
  localparam cal_idx_t CAL_NEG250 = 3'd5;
  localparam cal_idx_t CAL_NEG375 = 3'd6;

  localparam code_t CAL_RST_POS375 = 12'd2450;
  localparam code_t CAL_RST_POS250 = 12'd2300;
  localparam code_t CAL_RST_POS125 = 12'd2137;
  localparam code_t CAL_RST_ZERO   = 12'd1950;
  localparam code_t CAL_RST_NEG125 = 12'd1800;
  localparam code_t CAL_RST_NEG250 = 12'd1630;
  localparam code_t CAL_RST_NEG375 = 12'd1450;

  localparam code_t CODE_MAX = 12'd4095;

  // Segment geometry in mV (125 mV segments, span +/-375 mV).
  localparam logic [9:0] SEG_MV  = 10'd125;
  localparam logic signed [MV_W:0] SPAN_MV = 17'(3 * SEG_MV);
  localparam logic [9:0] SEG_B1  = SEG_MV;
  localparam logic [9:0] SEG_B2  = 10'(2 * SEG_MV);
  localparam logic [9:0] SEG_B3  = 10'(3 * SEG_MV);
  localparam logic [9:0] SEG_B4  = 10'(4 * SEG_MV);
  localparam logic [9:0] SEG_B5  = 10'(5 * SEG_MV);

  // Extrapolation slope 6/5; floor(x/5) and floor(x/125) by reciprocal.
  localparam logic [6:0]  EXT_SLOPE_NUM = 7'd6;
  localparam logic [6:0]  BIAS_DIV5     = 7'd4;
  localparam logic [6:0]  BIAS_DIV125   = 7'(SEG_MV - 1);
  localparam logic [14:0] RECIP_DIV5    = 15'd26215;   // ceil(2^17 / 5)
  localparam logic [19:0] RECIP_DIV125  = 20'((2**26 + SEG_MV - 1) / SEG_MV);  // ceil(2^26 / 125)

  typedef struct packed {
    code_t             base;
    logic              neg;
    logic              div5;
    logic [MAG_W-1:0]  mag;
  } mul_stage_t;

  typedef struct packed {
    code_t             base;
    logic              neg;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

endpackage

FILE: hw/rtl/dac_calibrated_offset_mapper.sv
// Calibrated offset-to-DAC-code mapper, top level.
// Depends on dcom_pkg, dcom_cfg, dcom_seg and dcom_div.
//
// Usage:
//   in_*  : one transaction per offset request, in_tdata = offset_mv (signed mV).
//   out_* : one transaction per new DAC code, out_tdata[11:0] = dac_code.
//           A code equal to the previously computed one produces no transaction.
//   cfg_* : writes calibration code cfg_index (0 = +375 mV ... 6 = -375 mV);
//           cfg_ready is always high, index 7 is ignored. Write only while idle.
// Timing:
//   Pipeline of input register, multiply stage, divide stage and output register.
//   out_tvalid is registered. One request is taken every cycle while in_tready
//   is high, set by the single multiply and the reciprocal divide per stage.
// Reset: calibration codes return to their factory values, last code to 0,
//   the pipeline empties.
// Stall: while out_tready is low, requests whose code is unchanged still drain;
//   a changed code waits in the divide stage and the stages behind it fill up,
//   after which in_tready drops.
module dac_calibrated_offset_mapper
  import dcom_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] offset_mv
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [11:0] dac_code, [15:12] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cal_idx_t    cfg_index,
  input  code_t       cfg_data
);

  cal_bank_t  cal;
  mv_t        mv_r;
  logic       v0_r;
  mul_stage_t op_nxt;
  mul_stage_t op_r;
  logic       v1_r;
  div_stage_t dv_nxt;
  div_stage_t dv_r;
  logic       v2_r;
  code_t      last_code_r;
  code_t      out_code_r;
  logic       out_tvalid_r;

  logic signed [14:0] code_raw;
  code_t              code_nxt;
  logic               changed;
  logic               out_free;
  logic               rdy0;
  logic               rdy1;
  logic               rdy2;

  dcom_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  dcom_seg u_seg (
    .mv  (mv_r),
    .cal (cal),
    .op  (op_nxt)
  );

  dcom_div u_div (
    .op  (op_r),
    .res (dv_nxt)
  );

  // final add and saturate
  always_comb begin
    if (dv_r.neg) begin
      code_raw = $signed({3'd0, dv_r.base}) - $signed({2'd0, dv_r.quo});
    end else begin
      code_raw = $signed({3'd0, dv_r.base}) + $signed({2'd0, dv_r.quo});
    end
    if (code_raw < 15'sd0) begin
      code_nxt = '0;
    end else if (code_raw > $signed({3'd0, CODE_MAX})) begin
      code_nxt = CODE_MAX;
    end else begin
      code_nxt = code_raw[CODE_W-1:0];
    end
  end

  assign changed  = (code_nxt != last_code_r);
  assign out_free = !out_tvalid_r || out_tready;
  // unchanged codes retire without needing the output register
  assign rdy2     = !v2_r || !changed || out_free;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;

  assign in_tready  = rdy0;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_code_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      last_code_r  <= '0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (v2_r && rdy2) last_code_r <= code_nxt;
      if (v2_r && rdy2 && changed) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy0) mv_r <= in_tdata;
    if (v0_r && rdy1) op_r <= op_nxt;
    if (v1_r && rdy2) dv_r <= dv_nxt;
    if (v2_r && rdy2 && changed) out_code_r <= code_nxt;
  end

endmodule

FILE: hw/rtl/dcom_cfg.sv
// Calibration register bank of the offset mapper.
// Seven 12-bit codes written through the configuration channel.
// Depends on dcom_pkg.
module dcom_cfg
  import dcom_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cal_idx_t  cfg_index,
  input  code_t     cfg_data,
  output cal_bank_t cal
);

  cal_bank_t cal_r;

  assign cfg_ready = 1'b1;
  assign cal       = cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r[CAL_POS375] <= CAL_RST_POS375;
      cal_r[CAL_POS250] <= CAL_RST_POS250;
      cal_r[CAL_POS125] <= CAL_RST_POS125;
      cal_r[CAL_ZERO]   <= CAL_RST_ZERO;
      cal_r[CAL_NEG125] <= CAL_RST_NEG125;
      cal_r[CAL_NEG250] <= CAL_RST_NEG250;
      cal_r[CAL_NEG375] <= CAL_RST_NEG375;
    end else if (cfg_valid) begin
      case (cfg_index)
        CAL_POS375: cal_r[CAL_POS375] <= cfg_data;
        CAL_POS250: cal_r[CAL_POS250] <= cfg_data;
        CAL_POS125: cal_r[CAL_POS125] <= cfg_data;
        CAL_ZERO:   cal_r[CAL_ZERO]   <= cfg_data;
        CAL_NEG125: cal_r[CAL_NEG125] <= cfg_data;
        CAL_NEG250: cal_r[CAL_NEG250] <= cfg_data;
        CAL_NEG375: cal_r[CAL_NEG375] <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

FILE: hw/rtl/dcom_seg.sv
// Segment select and slope multiply of the offset mapper.
// Picks interpolation or extrapolation, forms base code and |slope*offset|+bias.
// Depends on dcom_pkg.
module dcom_seg
  import dcom_pkg::*;
(
  input  mv_t        mv,
  input  cal_bank_t  cal,
  output mul_stage_t op
);

  logic signed [MV_W:0] mv_x;
  logic signed [MV_W:0] up_d;
  logic signed [MV_W:0] dn_d;
  logic signed [MV_W:0] span_u;
  logic [9:0]           u;
  logic [2:0]           seg;
  logic [9:0]           seg_base;
  logic [6:0]           t;
  code_t                lo;
  code_t                hi;
  logic signed [12:0]   diff;
  code_t                mul_a;
  logic [6:0]           mul_b;
  logic [6:0]           bias;

  always_comb begin
    mv_x     = {mv[MV_W-1], mv};
    up_d     = mv_x - SPAN_MV;
    dn_d     = -mv_x - SPAN_MV;
    span_u   = mv_x + SPAN_MV;
    u        = span_u[9:0];
    seg      = 3'd0;
    seg_base = 10'd0;
    t        = '0;
    lo       = cal[CAL_NEG375];
    hi       = cal[CAL_NEG250];
    diff     = 13'sd0;
    mul_a    = '0;
    mul_b    = '0;
    bias     = '0;
    op.base  = '0;
    op.neg   = 1'b0;
    op.div5  = 1'b0;

    if (mv_x >= SPAN_MV) begin
      // above the span: clamp the distance, anything past 4095 saturates
      mul_a   = (up_d > $signed({5'd0, CODE_MAX})) ? CODE_MAX : up_d[CODE_W-1:0];
      mul_b   = EXT_SLOPE_NUM;
      op.base = cal[CAL_POS375];
      op.div5 = 1'b1;
    end else if (mv_x < -SPAN_MV) begin
      // below the span: floor of a negative slope term, as a ceil of the magnitude
      mul_a   = (dn_d > $signed({5'd0, CODE_MAX})) ? CODE_MAX : dn_d[CODE_W-1:0];
      mul_b   = EXT_SLOPE_NUM;
      bias    = BIAS_DIV5;
      op.base = cal[CAL_NEG375];
      op.neg  = 1'b1;
      op.div5 = 1'b1;
    end else begin
      if (u >= SEG_B5) begin
        seg = 3'd5;  seg_base = SEG_B5;
      end else if (u >= SEG_B4) begin
        seg = 3'd4;  seg_base = SEG_B4;
      end else if (u >= SEG_B3) begin
        seg = 3'd3;  seg_base = SEG_B3;
      end else if (u >= SEG_B2) begin
        seg = 3'd2;  seg_base = SEG_B2;
      end else if (u >= SEG_B1) begin
        seg = 3'd1;  seg_base = SEG_B1;
      end
      case (seg)
        3'd0:    begin lo = cal[CAL_NEG375]; hi = cal[CAL_NEG250]; end
        3'd1:    begin lo = cal[CAL_NEG250]; hi = cal[CAL_NEG125]; end
        3'd2:    begin lo = cal[CAL_NEG125]; hi = cal[CAL_ZERO];   end
        3'd3:    begin lo = cal[CAL_ZERO];   hi = cal[CAL_POS125]; end
        3'd4:    begin lo = cal[CAL_POS125]; hi = cal[CAL_POS250]; end
        default: begin lo = cal[CAL_POS250]; hi = cal[CAL_POS375]; end
      endcase
      t       = 7'(u - seg_base);
      diff    = $signed({1'b0, hi}) - $signed({1'b0, lo});
      op.neg  = diff[12];
      mul_a   = diff[12] ? 12'(-diff) : diff[CODE_W-1:0];
      mul_b   = t;
      bias    = diff[12] ? BIAS_DIV125 : 7'd0;
      op.base = lo;
    end

    op.mag = MAG_W'(mul_a) * MAG_W'(mul_b) + MAG_W'(bias);
  end

endmodule

FILE: hw/rtl/dcom_div.sv
// Constant divide stage of the offset mapper.
// floor(mag/5) or floor(mag/125) by reciprocal multiply, exact over the input range.
// Depends on dcom_pkg.
module dcom_div
  import dcom_pkg::*;
(
  input  mul_stage_t op,
  output div_stage_t res
);

  logic [29:0] prod5;
  logic [38:0] prod125;

  always_comb begin
    prod5    = op.mag[14:0] * RECIP_DIV5;
    prod125  = op.mag * RECIP_DIV125;
    res.base = op.base;
    res.neg  = op.neg;
    res.quo  = op.div5 ? prod5[29:17] : prod125[38:26];
  end

endmodule
